@@ rtl/stsal_pkg.sv @@
// Package with the shared types, constants and codes of the slot table.
`default_nettype none
package stsal_pkg;
	localparam int MAX_SLOTS = 32;
	localparam int KEY_WIDTH = 32;
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_SORT = 2'd2;
	localparam logic [1:0] OP_FIND = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef logic [KEY_WIDTH-1:0] key_t;
	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic capture;
		logic add_commit;
		logic rem_scan_rd;
		logic rem_commit;
		logic srt_init;
		logic srt_rd_cur;
		logic srt_rd_prev;
		logic srt_shift;
		logic srt_place;
		logic srt_next_i;
		logic emit_init;
		logic emit_rd;
		logic find_init;
		logic find_rd_al;
		logic find_rd_key;
		logic find_step;
		logic find_rd_res;
		logic out_load;
		logic [1:0] out_kind;
	} cmd_t;

	localparam logic [1:0] OUT_ADD = 2'd0;
	localparam logic [1:0] OUT_REM = 2'd1;
	localparam logic [1:0] OUT_SORT = 2'd2;
	localparam logic [1:0] OUT_FIND = 2'd3;

	typedef struct packed {
		logic add_ok;
		logic rem_ok;
		logic rem_hit;
		logic rem_end;
		logic empty;
		logic srt_done;
		logic srt_move;
		logic srt_j_zero;
		logic emit_last;
		logic find_done;
	} sts_t;
endpackage
`default_nettype wire

@@ rtl/stsal_dp.sv @@
// Datapath of the slot table: key, list and stack memories and their index registers.
`default_nettype none
module stsal_dp import stsal_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire cmd_t cmd,
	output sts_t sts,
	input wire logic [1:0] op,
	input wire logic body_ok,
	input wire logic [4:0] slot,
	input wire logic signed [31:0] min_x,
	input wire logic signed [31:0] max_x,
	input wire logic signed [31:0] query_x,
	output logic [1:0] res_status,
	output logic [4:0] res_slot,
	output logic [5:0] res_position,
	output logic res_last
);
	key_t low_mem [MAX_SLOTS];
	key_t high_mem [MAX_SLOTS];
	slot_t al_mem [MAX_SLOTS];
	slot_t fs_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] in_use_q;
	cnt_t active_q, free_q;

	logic body_ok_q;
	logic [4:0] slot_q;
	key_t min_q, max_q, query_q;

	cnt_t i_q, j_q, lo_q, hi_q;
	slot_t cur_q, prev_q, al_rd_q, al_last_q, fs_top_q, res_al_q;
	key_t ck_q, pk_q, key_rd_q;
	logic fs_top_ok_q;

	key_t min_k, max_k, q_k;
	assign min_k = KEY_WIDTH'(min_x);
	assign max_k = KEY_WIDTH'(max_x);
	assign q_k = KEY_WIDTH'(query_x);

	logic slot_range;
	assign slot_range = 32'(slot_q) < MAX_SLOTS;

	slot_t add_slot;
	logic add_from_stack;
	assign add_from_stack = free_q != '0;
	assign add_slot = add_from_stack ? fs_top_q : active_q[SLOT_W-1:0];

	cnt_t mid;
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	assign sts.add_ok = body_ok_q && (add_from_stack || 32'(active_q) < MAX_SLOTS)
		&& 32'(active_q) < MAX_SLOTS;
	assign sts.rem_ok = slot_range && in_use_q[slot_q[SLOT_W-1:0]]
		&& 32'(free_q) < MAX_SLOTS;
	assign sts.rem_hit = al_rd_q == slot_q[SLOT_W-1:0];
	assign sts.rem_end = i_q >= active_q;
	assign sts.empty = active_q == '0;
	assign sts.srt_done = i_q >= active_q;
	assign sts.srt_move = $signed(pk_q) > $signed(ck_q);
	assign sts.srt_j_zero = j_q == '0;
	assign sts.emit_last = i_q + cnt_t'(1) == active_q;
	assign sts.find_done = lo_q >= hi_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			body_ok_q <= body_ok;
			slot_q <= slot;
			min_q <= min_k;
			max_q <= max_k;
			query_q <= q_k;
			fs_top_ok_q <= 1'b1;
		end
		fs_top_q <= fs_mem[SLOT_W'(free_q - cnt_t'(1))];
		al_rd_q <= al_mem[i_q[SLOT_W-1:0]];
		al_last_q <= al_mem[SLOT_W'(active_q - cnt_t'(1))];
		if (cmd.srt_rd_cur) begin
			cur_q <= al_mem[i_q[SLOT_W-1:0]];
		end
		if (cmd.srt_rd_prev) begin
			prev_q <= al_mem[SLOT_W'(j_q - cnt_t'(1))];
		end
		if (cmd.find_rd_al) begin
			res_al_q <= al_mem[mid[SLOT_W-1:0]];
		end
		if (cmd.find_rd_res) begin
			res_al_q <= al_mem[lo_q[SLOT_W-1:0]];
		end
		key_rd_q <= high_mem[res_al_q];
		ck_q <= low_mem[cur_q];
		pk_q <= low_mem[prev_q];
		if (cmd.add_commit) begin
			low_mem[add_slot] <= min_q;
			high_mem[add_slot] <= max_q;
			al_mem[active_q[SLOT_W-1:0]] <= add_slot;
		end
		if (cmd.rem_commit) begin
			fs_mem[free_q[SLOT_W-1:0]] <= slot_q[SLOT_W-1:0];
			al_mem[SLOT_W'(i_q - cnt_t'(1))] <= al_last_q;
		end
		if (cmd.srt_shift) begin
			al_mem[j_q[SLOT_W-1:0]] <= prev_q;
		end
		if (cmd.srt_place) begin
			al_mem[j_q[SLOT_W-1:0]] <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			active_q <= '0;
			free_q <= '0;
			i_q <= '0;
			j_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
		end else begin
			if (cmd.capture) begin
				i_q <= '0;
			end
			if (cmd.add_commit) begin
				in_use_q[add_slot] <= 1'b1;
				active_q <= active_q + cnt_t'(1);
				if (add_from_stack) begin
					free_q <= free_q - cnt_t'(1);
				end
			end
			if (cmd.rem_scan_rd) begin
				i_q <= i_q + cnt_t'(1);
			end
			if (cmd.rem_commit) begin
				in_use_q[slot_q[SLOT_W-1:0]] <= 1'b0;
				free_q <= free_q + cnt_t'(1);
				active_q <= active_q - cnt_t'(1);
			end
			if (cmd.srt_init) begin
				i_q <= cnt_t'(1);
			end
			if (cmd.srt_rd_cur) begin
				j_q <= i_q;
			end
			if (cmd.srt_shift) begin
				j_q <= j_q - cnt_t'(1);
			end
			if (cmd.srt_next_i) begin
				i_q <= i_q + cnt_t'(1);
			end
			if (cmd.emit_init) begin
				i_q <= '0;
			end
			if (cmd.emit_rd) begin
				i_q <= i_q + cnt_t'(1);
			end
			if (cmd.find_init) begin
				lo_q <= '0;
				hi_q <= active_q;
			end
			if (cmd.find_step) begin
				if ($signed(key_rd_q) < $signed(query_q)) begin
					lo_q <= mid + cnt_t'(1);
				end else begin
					hi_q <= mid;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_last <= 1'b1;
			res_status <= ST_OK;
			res_slot <= '0;
			res_position <= '0;
			case (cmd.out_kind)
				OUT_ADD: begin
					if (sts.add_ok) begin
						res_slot <= 5'(add_slot);
						res_position <= 6'(active_q);
					end else begin
						res_status <= ST_REFUSED;
					end
				end
				OUT_REM: begin
					if (sts.rem_ok && cmd.rem_commit) begin
						res_slot <= slot_q;
						res_position <= 6'(i_q - cnt_t'(1));
					end else begin
						res_status <= ST_REFUSED;
					end
				end
				OUT_SORT: begin
					if (sts.empty) begin
						res_status <= ST_EMPTY;
					end else begin
						res_slot <= 5'(al_rd_q);
						res_position <= 6'(i_q);
						res_last <= sts.emit_last;
					end
				end
				default: begin
					res_position <= 6'(lo_q);
					if (lo_q < active_q) begin
						res_slot <= 5'(res_al_q);
					end
				end
			endcase
		end
	end
	logic unused;
	assign unused = ^{op, fs_top_ok_q};
endmodule
`default_nettype wire

@@ rtl/stsal_ctrl.sv @@
// Controller state machine that sequences the slot table operations.
`default_nettype none
module stsal_ctrl import stsal_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] op,
	output logic out_valid,
	input wire logic out_stall,
	input wire sts_t sts,
	output cmd_t cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_DISP = 5'd1;
	localparam logic [4:0] S_ADD = 5'd2;
	localparam logic [4:0] S_RSCAN = 5'd3;
	localparam logic [4:0] S_RTEST = 5'd4;
	localparam logic [4:0] S_RLAST = 5'd5;
	localparam logic [4:0] S_RWAIT = 5'd6;
	localparam logic [4:0] S_RCOMMIT = 5'd7;
	localparam logic [4:0] S_TOP = 5'd8;
	localparam logic [4:0] S_TCUR = 5'd9;
	localparam logic [4:0] S_TPREV = 5'd10;
	localparam logic [4:0] S_TKEY = 5'd11;
	localparam logic [4:0] S_TCMP = 5'd12;
	localparam logic [4:0] S_ERD = 5'd13;
	localparam logic [4:0] S_EWAIT = 5'd14;
	localparam logic [4:0] S_EOUT = 5'd15;
	localparam logic [4:0] S_FTOP = 5'd16;
	localparam logic [4:0] S_FAL = 5'd17;
	localparam logic [4:0] S_FKEY = 5'd18;
	localparam logic [4:0] S_FCMP = 5'd19;
	localparam logic [4:0] S_FRES = 5'd20;
	localparam logic [4:0] S_FOUT = 5'd21;
	localparam logic [4:0] S_OUT = 5'd22;
	localparam logic [4:0] S_ADDW = 5'd23;
	localparam logic [4:0] S_REFUSE = 5'd24;
	localparam logic [4:0] S_TCUR2 = 5'd25;

	logic [4:0] state_q, state_d;
	logic [1:0] op_q;
	logic ovalid_q;
	logic emit_last_q;
	logic out_free;

	assign out_free = !ovalid_q || !out_stall;
	assign out_valid = ovalid_q;
	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (op_q)
					OP_ADD: state_d = S_ADDW;
					OP_REMOVE: begin
						if (sts.rem_ok) state_d = S_RSCAN;
						else state_d = S_REFUSE;
					end
					OP_SORT: begin
						if (sts.empty) state_d = S_REFUSE;
						else state_d = S_TOP;
					end
					default: state_d = S_FTOP;
				endcase
			end
			S_ADDW: state_d = S_ADD;
			S_ADD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_ADD;
					cmd.add_commit = sts.add_ok;
					state_d = S_IDLE;
				end
			end
			S_REFUSE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = (op_q == OP_SORT) ? OUT_SORT : OUT_REM;
					state_d = S_IDLE;
				end
			end
			S_RSCAN: begin
				if (sts.rem_end) begin
					state_d = S_REFUSE;
				end else begin
					cmd.rem_scan_rd = 1'b1;
					state_d = S_RTEST;
				end
			end
			S_RTEST: begin
				if (sts.rem_hit) state_d = S_RLAST;
				else state_d = S_RSCAN;
			end
			S_RLAST: state_d = S_RWAIT;
			S_RWAIT: state_d = S_RCOMMIT;
			S_RCOMMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_REM;
					cmd.rem_commit = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_TOP: begin
				cmd.srt_init = 1'b1;
				state_d = S_TCUR;
			end
			S_TCUR: begin
				if (sts.srt_done) begin
					cmd.emit_init = 1'b1;
					state_d = S_ERD;
				end else begin
					cmd.srt_rd_cur = 1'b1;
					state_d = S_TCUR2;
				end
			end
			S_TCUR2: state_d = S_TPREV;
			S_TPREV: begin
				if (sts.srt_j_zero) begin
					cmd.srt_place = 1'b1;
					cmd.srt_next_i = 1'b1;
					state_d = S_TCUR;
				end else begin
					cmd.srt_rd_prev = 1'b1;
					state_d = S_TKEY;
				end
			end
			S_TKEY: state_d = S_TCMP;
			S_TCMP: begin
				if (sts.srt_move) begin
					cmd.srt_shift = 1'b1;
					state_d = S_TPREV;
				end else begin
					cmd.srt_place = 1'b1;
					cmd.srt_next_i = 1'b1;
					state_d = S_TCUR;
				end
			end
			S_ERD: state_d = S_EWAIT;
			S_EWAIT: state_d = S_EOUT;
			S_EOUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_SORT;
					cmd.emit_rd = 1'b1;
					state_d = sts.emit_last ? S_IDLE : S_EWAIT;
				end
			end
			S_FTOP: begin
				cmd.find_init = 1'b1;
				state_d = S_FAL;
			end
			S_FAL: begin
				if (sts.find_done) begin
					cmd.find_rd_res = 1'b1;
					state_d = S_FRES;
				end else begin
					cmd.find_rd_al = 1'b1;
					state_d = S_FKEY;
				end
			end
			S_FKEY: state_d = S_FCMP;
			S_FCMP: begin
				cmd.find_step = 1'b1;
				state_d = S_FAL;
			end
			S_FRES: state_d = S_FOUT;
			S_FOUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_FIND;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= OP_ADD;
			ovalid_q <= 1'b0;
			emit_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.capture) op_q <= op;
			if (cmd.out_load) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
			emit_last_q <= sts.emit_last;
		end
	end
	logic unused;
	assign unused = emit_last_q;
endmodule
`default_nettype wire

@@ rtl/slot_table_sorted_active_list_top.sv @@
// Top level of the slot table with free stack and sortable active list.
`default_nettype none
// One request at a time: remove scans the list entries before it commits, find takes
// halving steps of the search, and sort runs the compares of the insertion sort over the
// list entries and then emits each entry. Results leave through an output register that
// holds while stalled.
module slot_table_sorted_active_list_top import stsal_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] op,
	input wire logic body_ok,
	input wire logic [4:0] slot,
	input wire logic signed [31:0] min_x,
	input wire logic signed [31:0] max_x,
	input wire logic signed [31:0] query_x,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [4:0] slot_out,
	output logic [5:0] position,
	output logic last
);
	cmd_t cmd;
	sts_t sts;

	stsal_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	stsal_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .op(op), .body_ok(body_ok),
		.slot(slot), .min_x(min_x), .max_x(max_x), .query_x(query_x),
		.res_status(status), .res_slot(slot_out), .res_position(position), .res_last(last)
	);

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_out))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> in_stall)
		else $error("request taken while busy");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && out_stall))
		else $error("result overwritten");
`endif
endmodule
`default_nettype wire

@@ dv/tb_slot_table_sorted_active_list_top.sv @@
// Testbench for the slot table with free stack and sortable active list.
`timescale 1ns / 100ps
`default_nettype none
module tb_slot_table_sorted_active_list_top;
	import stsal_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] slot_out;
		logic [5:0] position;
		logic last;
	} slot_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic body_ok;
	logic [4:0] slot;
	logic signed [31:0] min_x;
	logic signed [31:0] max_x;
	logic signed [31:0] query_x;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic [4:0] slot_out;
	logic [5:0] position;
	logic last;

	logic signed [31:0] lo_key [MAX_SLOTS];
	logic signed [31:0] hi_key [MAX_SLOTS];
	logic [4:0] live_list [MAX_SLOTS];
	int live_count;
	logic [4:0] spare_stack [MAX_SLOTS];
	int spare_count;
	bit in_use [MAX_SLOTS];

	slot_result_t expected_q [$];
	int errors;

	slot_table_sorted_active_list_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic slot_result_t mk(logic [1:0] st, logic [4:0] s, int pos, bit l);
		slot_result_t r;
		r.status = st;
		r.slot_out = s;
		r.position = pos[5:0];
		r.last = l;
		return r;
	endfunction

	task automatic predict_table(logic [1:0] o, logic b, logic [4:0] s,
			logic signed [31:0] lk, logic signed [31:0] hk, logic signed [31:0] q);
		logic [4:0] ns;
		logic [4:0] cur;
		int i;
		int j;
		int lo;
		int hi;
		int mid;
		case (o)
			OP_ADD: begin
				if (!b || (spare_count == 0 && live_count >= MAX_SLOTS)) begin
					expected_q.push_back(mk(ST_REFUSED, '0, 0, 1'b1));
				end else begin
					if (spare_count > 0) begin
						spare_count--;
						ns = spare_stack[spare_count];
					end else begin
						ns = live_count[4:0];
					end
					lo_key[ns] = lk;
					hi_key[ns] = hk;
					in_use[ns] = 1'b1;
					live_list[live_count] = ns;
					expected_q.push_back(mk(ST_OK, ns, live_count, 1'b1));
					live_count++;
				end
			end
			OP_REMOVE: begin
				if (!in_use[s]) begin
					expected_q.push_back(mk(ST_REFUSED, '0, 0, 1'b1));
				end else begin
					for (i = 0; i < live_count; i++)
						if (live_list[i] == s)
							break;
					live_count--;
					live_list[i] = live_list[live_count];
					in_use[s] = 1'b0;
					spare_stack[spare_count] = s;
					spare_count++;
					expected_q.push_back(mk(ST_OK, s, i, 1'b1));
				end
			end
			OP_SORT: begin
				if (live_count == 0) begin
					expected_q.push_back(mk(ST_EMPTY, '0, 0, 1'b1));
				end else begin
					for (i = 1; i < live_count; i++) begin
						cur = live_list[i];
						j = i;
						while (j > 0 && lo_key[live_list[j-1]] > lo_key[cur]) begin
							live_list[j] = live_list[j-1];
							j--;
						end
						live_list[j] = cur;
					end
					for (i = 0; i < live_count; i++)
						expected_q.push_back(mk(ST_OK, live_list[i], i,
							i + 1 == live_count));
				end
			end
			default: begin
				lo = 0;
				hi = live_count;
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (hi_key[live_list[mid]] < q)
						lo = mid + 1;
					else
						hi = mid;
				end
				expected_q.push_back(mk(ST_OK, lo < live_count ? live_list[lo] : 5'd0,
					lo, 1'b1));
			end
		endcase
	endtask

	task automatic send_request(logic [1:0] o, logic b, logic [4:0] s,
			logic signed [31:0] lk, logic signed [31:0] hk, logic signed [31:0] q);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		body_ok <= b;
		slot <= s;
		min_x <= lk;
		max_x <= hk;
		query_x <= q;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_table(o, b, s, lk, hk, q);
		@(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed($urandom_range(0, 7)) - 3;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] pick_slot();
		if (live_count > 0 && $urandom_range(0, 3) != 0)
			return live_list[$urandom_range(0, live_count - 1)];
		return 5'($urandom);
	endfunction

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic test_directed();
		send_request(OP_SORT, 1'b1, 5'd0, 0, 0, 0);
		send_request(OP_FIND, 1'b1, 5'd0, 0, 0, 32'sh7fffffff);
		send_request(OP_REMOVE, 1'b1, 5'd31, 0, 0, 0);
		send_request(OP_ADD, 1'b0, 5'd0, 1, 1, 0);
		send_request(OP_ADD, 1'b1, 5'd0, 32'sh7fffffff, 32'sh7fffffff, 0);
		send_request(OP_ADD, 1'b1, 5'd0, 32'sh80000000, 32'sh80000000, 0);
		send_request(OP_ADD, 1'b1, 5'd0, 0, 32'sh00010000, 0);
		send_request(OP_ADD, 1'b1, 5'd0, 0, -1, 0);
		send_request(OP_SORT, 1'b1, 5'd0, 0, 0, 0);
		send_request(OP_FIND, 1'b1, 5'd0, 0, 0, 32'sh80000000);
		send_request(OP_FIND, 1'b1, 5'd0, 0, 0, 32'sh7fffffff);
		send_request(OP_FIND, 1'b1, 5'd0, 0, 0, 0);
		send_request(OP_REMOVE, 1'b1, 5'd1, 0, 0, 0);
		send_request(OP_REMOVE, 1'b1, 5'd1, 0, 0, 0);
		send_request(OP_ADD, 1'b1, 5'd0, 5, 6, 0);
		drain_results();
	endtask

	task automatic test_full_table();
		int i;
		for (i = 0; i < 30; i++)
			send_request(OP_ADD, 1'b1, 5'd0, rand_key(), rand_key(), 0);
		send_request(OP_ADD, 1'b1, 5'd0, 0, 0, 0);
		send_request(OP_SORT, 1'b1, 5'd0, 0, 0, 0);
		send_request(OP_REMOVE, 1'b1, 5'd31, 0, 0, 0);
		send_request(OP_REMOVE, 1'b1, 5'd0, 0, 0, 0);
		drain_results();
	endtask

	task automatic test_random();
		int i;
		int r;
		for (i = 0; i < 130; i++) begin
			r = $urandom_range(0, 99);
			if (r < 30)
				send_request(OP_ADD, $urandom_range(0, 9) != 0, 5'($urandom),
					rand_key(), rand_key(), $urandom);
			else if (r < 60)
				send_request(OP_REMOVE, 1'($urandom), pick_slot(), $urandom, $urandom,
					$urandom);
			else if (r < 72)
				send_request(OP_SORT, 1'($urandom), 5'($urandom), $urandom, $urandom,
					$urandom);
			else
				send_request(OP_FIND, 1'($urandom), 5'($urandom), $urandom, $urandom,
					rand_key());
			if (i == 65)
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		slot_result_t exp_r;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, status);
						errors++;
					end
					if (slot_out !== exp_r.slot_out) begin
						$error("slot_out exp %0d got %0d", exp_r.slot_out, slot_out);
						errors++;
					end
					if (position !== exp_r.position) begin
						$error("position exp %0d got %0d", exp_r.position, position);
						errors++;
					end
					if (last !== exp_r.last) begin
						$error("last exp %0d got %0d", exp_r.last, last);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		int g;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			g = gap_len();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
		end
	end

	initial begin
		errors = 0;
		live_count = 0;
		spare_count = 0;
		foreach (in_use[i])
			in_use[i] = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ADD;
		body_ok = 1'b0;
		slot = '0;
		min_x = '0;
		max_x = '0;
		query_x = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_random();
		if (errors == 0 && expected_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/stsal_pkg.sv
rtl/stsal_dp.sv
rtl/stsal_ctrl.sv
rtl/slot_table_sorted_active_list_top.sv
dv/tb_slot_table_sorted_active_list_top.sv
